[design/acc_pkg.sv]
// Types and constants for the AVCC to Annex B converter.
// Shared by acc_core, acc_outbuf and the top level; no dependencies.
package acc_pkg;

	localparam logic [31:0] MAX_PACKET_BYTES = 32'd1048576;

	// closing report status codes
	localparam logic [1:0] ST_OK             = 2'd0;
	localparam logic [1:0] ST_OVERRUN        = 2'd1;
	localparam logic [1:0] ST_PREFIX_CUT     = 2'd2;
	localparam logic [1:0] ST_NOT_CONFIGURED = 2'd3;

	// configuration register indexes
	localparam logic CFG_PREFIX_BYTES = 1'b0;
	localparam logic CFG_FORMAT_READY = 1'b1;

	localparam logic [2:0] PREFIX_BYTES_RESET = 3'd4;
	localparam logic [2:0] PREFIX_BYTES_MAX   = 3'd4;

	localparam int unsigned START_LEN = 4;
	localparam logic [START_LEN-1:0][7:0] START_CODE = {8'h01, 8'h00, 8'h00, 8'h00};

	typedef struct packed {
		logic [7:0]  in_byte;
		logic [19:0] bytes_after;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        packet_end;
		logic [31:0] total_bytes;
		logic [1:0]  status;
	} out_item_t;

	// results produced by one input byte, entry 0 first
	typedef struct packed {
		logic [2:0]                     count;
		out_item_t [START_LEN-1:0]      items;
	} batch_t;

endpackage

[design/acc_core.sv]
// Parser core: holds configuration and per-packet state, turns one byte into
// a batch of up to four results. Depends on acc_pkg.
module acc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic              go,
	input  acc_pkg::in_item_t item,
	output acc_pkg::batch_t   batch
);
	import acc_pkg::*;

	logic [2:0]  prefix_bytes_q;
	logic        format_ready_q;

	logic        in_payload_q, in_payload_d;
	logic [1:0]  prefix_seen_q, prefix_seen_d;
	logic [31:0] length_q, length_d;
	logic [19:0] left_q, left_d;
	logic [31:0] out_count_q, out_count_d;
	logic        dropping_q, dropping_d;
	logic [1:0]  err_q, err_d;

	logic [2:0]  need;
	logic        last;
	logic [31:0] acc;
	logic [2:0]  n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_bytes_q <= PREFIX_BYTES_RESET;
			format_ready_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PREFIX_BYTES: prefix_bytes_q <= cfg_data;
				CFG_FORMAT_READY: format_ready_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// 0 acts as 1, anything above 4 acts as 4
		if (prefix_bytes_q == 3'd0)
			need = 3'd1;
		else if (prefix_bytes_q > PREFIX_BYTES_MAX)
			need = PREFIX_BYTES_MAX;
		else
			need = prefix_bytes_q;

		last = (item.bytes_after == 20'd0);
		acc  = {length_q[23:0], item.in_byte};

		in_payload_d  = in_payload_q;
		prefix_seen_d = prefix_seen_q;
		length_d      = length_q;
		left_d        = left_q;
		out_count_d   = out_count_q;
		dropping_d    = dropping_q;
		err_d         = err_q;
		n             = 3'd0;
		batch.items   = '0;

		if (!format_ready_q && !dropping_q) begin
			dropping_d = 1'b1;
			err_d      = ST_NOT_CONFIGURED;
		end

		if (!dropping_d) begin
			if (in_payload_q) begin
				batch.items[0].out_byte = item.in_byte;
				n           = 3'd1;
				out_count_d = out_count_q + 32'd1;
				left_d      = left_q - 20'd1;
				if (left_d == 20'd0)
					in_payload_d = 1'b0;
				else if (last)
					err_d = ST_OVERRUN;
			end else begin
				length_d = acc;
				if ({1'b0, prefix_seen_q} + 3'd1 >= need) begin
					prefix_seen_d = 2'd0;
					length_d      = 32'd0;
					if (acc > {12'd0, item.bytes_after} || acc >= MAX_PACKET_BYTES) begin
						dropping_d = 1'b1;
						err_d      = ST_OVERRUN;
					end else if (acc != 32'd0) begin
						for (int i = 0; i < START_LEN; i++)
							batch.items[i].out_byte = START_CODE[i];
						n            = 3'(START_LEN);
						out_count_d  = out_count_q + 32'(START_LEN);
						in_payload_d = 1'b1;
						left_d       = acc[19:0];
					end
				end else begin
					prefix_seen_d = prefix_seen_q + 2'd1;
					if (last)
						err_d = ST_PREFIX_CUT;
				end
			end
		end

		// a start code never comes with the last byte, so the report fits
		if (last) begin
			batch.items[n[1:0]].packet_end  = 1'b1;
			batch.items[n[1:0]].total_bytes = out_count_d;
			batch.items[n[1:0]].status      = err_d;
			n             = n + 3'd1;
			in_payload_d  = 1'b0;
			prefix_seen_d = 2'd0;
			length_d      = 32'd0;
			left_d        = 20'd0;
			out_count_d   = 32'd0;
			dropping_d    = 1'b0;
			err_d         = ST_OK;
		end

		batch.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q  <= 1'b0;
			prefix_seen_q <= 2'd0;
			length_q      <= 32'd0;
			left_q        <= 20'd0;
			out_count_q   <= 32'd0;
			dropping_q    <= 1'b0;
			err_q         <= ST_OK;
		end else if (go) begin
			in_payload_q  <= in_payload_d;
			prefix_seen_q <= prefix_seen_d;
			length_q      <= length_d;
			left_q        <= left_d;
			out_count_q   <= out_count_d;
			dropping_q    <= dropping_d;
			err_q         <= err_d;
		end
	end

endmodule

[design/acc_outbuf.sv]
// Result buffer: takes a batch of up to four results and hands them out one
// request per cycle while dst_stall is low, oldest first. Depends on acc_pkg.
module acc_outbuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  acc_pkg::batch_t    batch,
	output logic               can_load,
	output logic               dst_valid,
	input  logic               dst_stall,
	output acc_pkg::out_item_t dst_data
);
	import acc_pkg::*;

	out_item_t [START_LEN-1:0] buf_q;
	logic [2:0]                cnt_q;
	logic                      pop;

	assign dst_valid = (cnt_q != 3'd0);
	assign dst_data  = buf_q[0];
	assign pop       = dst_valid && !dst_stall;
	// refill as the final entry leaves, keeping one result per cycle unless stalled
	assign can_load  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= batch.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= batch.items;
		end else if (pop) begin
			for (int i = 0; i < START_LEN - 1; i++)
				buf_q[i] <= buf_q[i+1];
		end
	end

endmodule

[design/avcc_to_annexb_converter.sv]
// AVCC to Annex B converter, top level: input register, parser core and
// result buffer. Depends on acc_pkg, acc_core and acc_outbuf.
//
// Usage: packet bytes arrive on src (valid/stall) with the count of bytes
// still to follow; 0 marks the packet's last byte. Each nonzero-length unit
// is written to dst as 00 00 00 01 followed by its payload bytes. After the
// last byte a closing report (packet_end = 1) gives the output byte count
// and the status. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle: index 0 is prefix_bytes, index 1 format_ready.
// The first result of a byte is offered on dst once the byte's request has
// passed the input register and then been loaded into the result buffer.
// Throughput: one result request per cycle on dst while dst_stall is low;
// a payload byte is taken every cycle unless dst stalls; a byte completing a
// prefix emits four requests and holds the input until the result buffer
// has handed out all but the last of them and that one leaves.
// Reset clears all packet state, sets prefix_bytes to 4 and format_ready to 0
// (unconfigured: packets are dropped and reported with status 3).
// A stall on dst holds the current result; once the buffer and input
// register are full, src_stall rises and no byte is lost.
module avcc_to_annexb_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  acc_pkg::in_item_t  src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output acc_pkg::out_item_t dst_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [2:0]         cfg_data
);
	import acc_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	logic     can_load;
	logic     go;
	batch_t   batch;

	assign go        = valid_s1 && can_load;
	assign src_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			item_s1 <= src_data;
		end
	end

	acc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.go        (go),
		.item      (item_s1),
		.batch     (batch)
	);

	acc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go),
		.batch     (batch),
		.can_load  (can_load),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

endmodule

[tb/avcc_to_annexb_converter_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for avcc_to_annexb_converter: length-prefixed packets in,
// start-code framed stream and closing reports out, checked by a predictor.
// Depends on acc_pkg and the design sources only.
module avcc_to_annexb_converter_test;
	import acc_pkg::*;

	localparam int LONG_HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES    = 10;
	localparam int WATCHDOG_CYCLES  = 2000;
	localparam int PHASE_ITEMS      = 7;

	// Predicts the converted stream byte by byte and checks the block against it.
	class annexb_scoreboard;
		logic [2:0]  prefix_cfg;
		logic        ready_cfg;
		logic        in_payload;
		logic [1:0]  prefix_seen;
		logic [31:0] length_accum;
		logic [19:0] payload_left;
		logic [31:0] out_count;
		logic        dropping;
		logic [1:0]  error_code;
		out_item_t   expected_stream[$];
		int          errors;

		function new();
			prefix_cfg = PREFIX_BYTES_RESET;
			ready_cfg  = 1'b0;
			errors     = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			in_payload   = 1'b0;
			prefix_seen  = 2'd0;
			length_accum = 32'd0;
			payload_left = 20'd0;
			out_count    = 32'd0;
			dropping     = 1'b0;
			error_code   = ST_OK;
		endfunction

		function void write_reg(logic idx, logic [2:0] val);
			if (idx == CFG_PREFIX_BYTES)
				prefix_cfg = val;
			else
				ready_cfg = val[0];
		endfunction

		// 0 behaves as 1, anything above 4 as 4
		function int prefix_len();
			if (prefix_cfg == 3'd0)
				return 1;
			if (prefix_cfg > PREFIX_BYTES_MAX)
				return int'(PREFIX_BYTES_MAX);
			return int'(prefix_cfg);
		endfunction

		function int pending();
			return expected_stream.size();
		endfunction

		function void expect_out(logic [7:0] b, logic fin, logic [31:0] total, logic [1:0] st);
			out_item_t item;
			item.out_byte    = b;
			item.packet_end  = fin;
			item.total_bytes = total;
			item.status      = st;
			expected_stream.push_back(item);
		endfunction

		function void note_packet_byte(in_item_t req);
			logic        last;
			logic [31:0] len;
			last = (req.bytes_after == 20'd0);
			if (!ready_cfg && !dropping) begin
				dropping   = 1'b1;
				error_code = ST_NOT_CONFIGURED;
			end
			if (!dropping) begin
				if (in_payload) begin
					expect_out(req.in_byte, 1'b0, 32'd0, ST_OK);
					out_count    = out_count + 32'd1;
					payload_left = payload_left - 20'd1;
					if (payload_left == 20'd0)
						in_payload = 1'b0;
					else if (last)
						error_code = ST_OVERRUN;
				end else begin
					length_accum = {length_accum[23:0], req.in_byte};
					if (int'(prefix_seen) + 1 >= prefix_len()) begin
						len          = length_accum;
						prefix_seen  = 2'd0;
						length_accum = 32'd0;
						if (len > {12'd0, req.bytes_after} || len >= MAX_PACKET_BYTES) begin
							dropping   = 1'b1;
							error_code = ST_OVERRUN;
						end else if (len != 32'd0) begin
							for (int i = 0; i < START_LEN; i++)
								expect_out(START_CODE[i], 1'b0, 32'd0, ST_OK);
							out_count    = out_count + START_LEN;
							in_payload   = 1'b1;
							payload_left = len[19:0];
						end
					end else begin
						prefix_seen = prefix_seen + 2'd1;
						if (last)
							error_code = ST_PREFIX_CUT;
					end
				end
			end
			if (last) begin
				expect_out(8'd0, 1'b1, out_count, error_code);
				clear_packet();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_stream_item(out_item_t got);
			out_item_t want;
			if (expected_stream.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, %s %0h end %0b total %0d status %0d",
					$time, "actual byte", got.out_byte, got.packet_end, got.total_bytes,
					got.status);
				return;
			end
			want = expected_stream.pop_front();
			compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
			compare_field("packet_end", 32'(want.packet_end), 32'(got.packet_end));
			compare_field("total_bytes", want.total_bytes, got.total_bytes);
			compare_field("status", 32'(want.status), 32'(got.status));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       src_valid;
	logic       src_stall;
	in_item_t   src_data;
	logic       dst_valid;
	logic       dst_stall;
	out_item_t  dst_data;
	logic       cfg_we;
	logic       cfg_index;
	logic [2:0] cfg_data;

	int src_idle_pct;
	int dst_stall_pct;
	bit long_hold_req;

	annexb_scoreboard sb;

	avcc_to_annexb_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		sb = new();
	end

	always @(posedge clk) begin
		if (arst_n && src_valid && !src_stall)
			sb.note_packet_byte(src_data);
		if (arst_n && dst_valid && !dst_stall)
			sb.check_stream_item(dst_data);
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		dst_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				dst_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			dst_stall <= (dst_stall_pct != 0) && ($urandom_range(99) < dst_stall_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// valid is left high on return so back-to-back requests need no toggle
	task automatic send_item(input logic [7:0] b, input logic [19:0] after);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= '{in_byte: b, bytes_after: after};
		do @(posedge clk); while (src_stall);
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input logic [2:0] prefix, input logic ready);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PREFIX_BYTES;
		cfg_data  <= prefix;
		@(posedge clk);
		sb.write_reg(CFG_PREFIX_BYTES, prefix);
		cfg_index <= CFG_FORMAT_READY;
		cfg_data  <= {2'b00, ready};
		@(posedge clk);
		sb.write_reg(CFG_FORMAT_READY, {2'b00, ready});
		cfg_we <= 1'b0;
	endtask

	// whole units with random payload; cut = drop the tail to break the packet
	task automatic send_unit_packet(input bit cut, inout int sent);
		logic [7:0]  pkt[$];
		logic [31:0] len_word;
		int          units;
		int          len;
		int          need;
		int          keep;
		need  = sb.prefix_len();
		units = $urandom_range(1, 3);
		repeat (units) begin
			len      = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
			len_word = len;
			for (int k = need - 1; k >= 0; k--)
				pkt.push_back(len_word[8*k +: 8]);
			repeat (len) pkt.push_back(8'($urandom_range(255)));
		end
		if (cut) begin
			keep = $urandom_range(1, pkt.size());
			while (pkt.size() > keep) void'(pkt.pop_back());
		end
		foreach (pkt[i])
			send_item(pkt[i], 20'(pkt.size() - 1 - i));
		sent += pkt.size();
	endtask

	// arbitrary bytes with arbitrary remaining counts, closed by a last byte
	task automatic send_noise_packet(inout int sent);
		int n;
		n = $urandom_range(1, 6);
		for (int i = n - 1; i >= 0; i--)
			send_item(8'($urandom_range(255)),
				(i == 0) ? 20'd0 : 20'($urandom_range(20'hFFFFF, 1)));
		sent += n;
	endtask

	initial begin
		logic [2:0] phase_prefix[8];
		int         sent;
		int         pick;
		phase_prefix = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd1, 3'd4};
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		long_hold_req = 1'b0;
		arst_n    <= 1'b0;
		src_valid <= 1'b0;
		src_data  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_PREFIX_BYTES;
		cfg_data  <= 3'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset the block is unconfigured: whole packet dropped
		send_item(8'hA5, 20'd1);
		send_item(8'h5A, 20'd0);
		wait_drained();

		write_format(3'd1, 1'b1);
		// zero-length unit skipped, then a two-byte unit
		send_item(8'h00, 20'd3);
		send_item(8'h02, 20'd2);
		send_item(8'hFF, 20'd1);
		send_item(8'h00, 20'd0);
		// packet ends while payload is still owed
		send_item(8'h03, 20'd5);
		send_item(8'hAA, 20'd0);
		// unit longer than the rest of the packet
		send_item(8'h09, 20'd2);
		send_item(8'h11, 20'd1);
		send_item(8'h22, 20'd0);
		// largest remaining count
		send_item(8'hFF, 20'hFFFFF);
		send_item(8'h80, 20'd0);
		wait_drained();

		write_format(3'd4, 1'b1);
		// packet ends inside the prefix
		send_item(8'h00, 20'd2);
		send_item(8'h00, 20'd1);
		send_item(8'h00, 20'd0);
		send_item(8'h00, 20'd4);
		send_item(8'h00, 20'd3);
		send_item(8'h00, 20'd2);
		send_item(8'h01, 20'd1);
		send_item(8'h77, 20'd0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin
					src_idle_pct  = 0;
					dst_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 45;
					dst_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					dst_stall_pct = 45;
				end
				default: begin
					src_idle_pct  = 25;
					dst_stall_pct = 25;
				end
			endcase
			write_format(phase_prefix[p], 1'b1);
			if (p == 2)
				long_hold_req = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 70)
					send_unit_packet(1'b0, sent);
				else if (pick < 85)
					send_unit_packet(1'b1, sent);
				else
					send_noise_packet(sent);
				if (p == 5 && sent >= PHASE_ITEMS / 2 && sent < PHASE_ITEMS) begin
					wait_drained();
					sent = PHASE_ITEMS - 1;
				end
			end
			wait_drained();

			if (p == 3) begin
				// dropped while unconfigured, then back to normal
				write_format(3'd2, 1'b0);
				sent = 0;
				send_unit_packet(1'b0, sent);
				wait_drained();
			end
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
